// ===== src/p2rgb_pkg.sv =====
// Package for the planar to RGB decoder: payload structs, queue entry,
// item kinds, color mode and register codes, and small color helpers.
// No dependencies.
`default_nettype none

package p2rgb_pkg;

    localparam int NUM_BYTES   = 6;
    localparam int QUEUE_DEPTH = 2;

    // register indexes
    localparam logic [1:0] CFG_PLANE_COUNT = 2'd0;
    localparam logic [1:0] CFG_COLOR_MODE  = 2'd1;

    // color modes; the undefined code decodes as normal
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_EHB    = 2'd1;
    localparam logic [1:0] MODE_HAM    = 2'd2;

    // input item mode field
    localparam logic ITEM_PIXELS  = 1'b0;
    localparam logic ITEM_PALETTE = 1'b1;

    // HAM control codes
    localparam logic [1:0] HAM_LOAD  = 2'd0;
    localparam logic [1:0] HAM_BLUE  = 2'd1;
    localparam logic [1:0] HAM_RED   = 2'd2;
    localparam logic [1:0] HAM_GREEN = 2'd3;

    typedef enum logic [1:0] {
        KIND_PIXELS,
        KIND_WRITE,
        KIND_CLEAR,
        KIND_SKIP
    } item_kind_t;

    typedef struct packed {
        logic        mode;
        logic [7:0]  plane_byte0;
        logic [7:0]  plane_byte1;
        logic [7:0]  plane_byte2;
        logic [7:0]  plane_byte3;
        logic [7:0]  plane_byte4;
        logic [7:0]  plane_byte5;
        logic [3:0]  pixel_count;
        logic        line_start;
        logic [4:0]  palette_index;
        logic [11:0] palette_color;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } out_item_t;

    typedef struct packed {
        item_kind_t                  kind;
        logic [3:0]                  count;
        logic                        line_start;
        logic [NUM_BYTES-1:0][7:0]   planes;
        logic [4:0]                  palette_index;
        logic [11:0]                 palette_color;
    } entry_t;

    // one pixel between palette read and color stage
    typedef struct packed {
        logic       emit;
        logic       clr;
        logic       ham;
        logic       half;
        logic [1:0] ctrl;
        logic [3:0] data;
        logic       last;
    } pix_op_t;

    // 4-bit level times 17
    function automatic logic [7:0] lvl17(input logic [3:0] l);
        return {l, l};
    endfunction

    function automatic logic [7:0] lvl_out(input logic [3:0] l, input logic half);
        logic [7:0] v;
        v = lvl17(l);
        return half ? {1'b0, v[7:1]} : v;
    endfunction

endpackage

`default_nettype wire

// ===== src/p2rgb_front.sv =====
// Front end: classifies an input transaction into a queue entry, clamps the
// pixel count and zeroes bitplanes beyond the active plane count.
// Depends on p2rgb_pkg.
`default_nettype none

module p2rgb_front #(
    parameter int PLANES_MAX      = 6,
    parameter int PIXELS_PER_ITEM = 8
) (
    input  var p2rgb_pkg::in_item_t in_item,
    input  wire logic [2:0]         plane_count,
    output var p2rgb_pkg::entry_t   entry
);
    import p2rgb_pkg::*;

    logic [3:0]                planes_eff;
    logic [NUM_BYTES-1:0][7:0] raw_planes;

    assign raw_planes = {in_item.plane_byte5, in_item.plane_byte4, in_item.plane_byte3,
                         in_item.plane_byte2, in_item.plane_byte1, in_item.plane_byte0};

    always_comb begin
        if (plane_count == 3'd0) begin
            planes_eff = 4'd1;
        end else if (int'(plane_count) > PLANES_MAX) begin
            planes_eff = 4'(PLANES_MAX);
        end else begin
            planes_eff = {1'b0, plane_count};
        end
    end

    always_comb begin
        entry = '0;
        entry.line_start    = in_item.line_start;
        entry.palette_index = in_item.palette_index;
        entry.palette_color = in_item.palette_color;
        if (int'(in_item.pixel_count) > PIXELS_PER_ITEM) begin
            entry.count = 4'(PIXELS_PER_ITEM);
        end else begin
            entry.count = in_item.pixel_count;
        end
        for (int p = 0; p < NUM_BYTES; p++) begin
            entry.planes[p] = (p < int'(planes_eff)) ? raw_planes[p] : 8'd0;
        end
        if (in_item.mode == ITEM_PALETTE) begin
            entry.kind = KIND_WRITE;
        end else if (entry.count != 4'd0) begin
            entry.kind = KIND_PIXELS;
        end else if (in_item.line_start) begin
            entry.kind = KIND_CLEAR;
        end else begin
            entry.kind = KIND_SKIP;
        end
    end

endmodule

`default_nettype wire

// ===== src/p2rgb_queue.sv =====
// Two-entry first-word-fall-through queue between front and back end.
// Depends on p2rgb_pkg.
`default_nettype none

module p2rgb_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  var p2rgb_pkg::entry_t in_entry,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output var p2rgb_pkg::entry_t out_entry
);
    import p2rgb_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    entry_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic            push, pop;

    assign in_ready  = (fill_reg != CW'(QUEUE_DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_entry = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] ptr);
        return (int'(ptr) == QUEUE_DEPTH - 1) ? '0 : PW'(ptr + 1'b1);
    endfunction

    always_comb begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = CW'(fill_reg + 1'b1);
        end else if (pop && !push) begin
            fill_next = CW'(fill_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

`default_nettype wire

// ===== src/p2rgb_back.sv =====
// Back end: pixel sequencer, palette memory with registered read, HAM/EHB
// color stage and output register. Depends on p2rgb_pkg.
`default_nettype none

module p2rgb_back #(
    parameter int PALETTE_DEPTH = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [1:0]          color_mode,
    input  wire logic                head_valid,
    output logic                     head_pop,
    input  var p2rgb_pkg::entry_t    head,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output var p2rgb_pkg::out_item_t m_data
);
    import p2rgb_pkg::*;

    localparam int AW = $clog2(PALETTE_DEPTH);

    logic [11:0]   pal_mem [PALETTE_DEPTH];
    logic [11:0]   rdata_reg;

    logic [3:0]    x_reg, x_next;
    logic          b_valid_reg;
    pix_op_t       b_op_reg;
    logic [11:0]   held_reg, held_next;
    logic          m_valid_reg, m_valid_next;
    out_item_t     m_data_reg, m_data_next;

    logic          advance, issue, is_last;
    logic [5:0]    pix;
    logic [4:0]    raw_addr;
    logic [AW-1:0] rd_addr, wr_addr;
    pix_op_t       a_op;
    logic          a_valid;
    logic [11:0]   base, color;

    function automatic logic [AW-1:0] pal_addr(input logic [4:0] idx);
        logic [5:0] v;
        v = {1'b0, idx};
        if (int'(idx) >= PALETTE_DEPTH) begin
            v = 6'(int'(idx) - PALETTE_DEPTH);
        end
        return AW'(v);
    endfunction

    assign advance = !m_valid_reg || m_ready;
    assign issue   = advance && head_valid;
    assign is_last = (x_reg == 4'(head.count - 1'b1));

    // gather one bit per plane for pixel x; positions past the byte are zero
    always_comb begin
        for (int p = 0; p < NUM_BYTES; p++) begin
            pix[p] = (x_reg < 4'd8) ? head.planes[p][~x_reg[2:0]] : 1'b0;
        end
    end

    always_comb begin
        a_op      = '0;
        a_op.ham  = (color_mode == MODE_HAM);
        a_op.half = (color_mode == MODE_EHB) && pix[5];
        a_op.ctrl = pix[5:4];
        a_op.data = pix[3:0];
        a_op.last = is_last;
        a_valid   = 1'b0;
        head_pop  = 1'b0;
        x_next    = x_reg;
        raw_addr  = a_op.ham ? {1'b0, pix[3:0]} : pix[4:0];
        case (head.kind)
            KIND_PIXELS: begin
                a_valid  = 1'b1;
                a_op.emit = 1'b1;
                a_op.clr  = head.line_start && (x_reg == 4'd0);
                if (issue) begin
                    head_pop = is_last;
                    x_next   = is_last ? 4'd0 : 4'(x_reg + 1'b1);
                end
            end
            KIND_CLEAR: begin
                a_valid  = 1'b1;
                a_op.clr = 1'b1;
                head_pop = issue;
            end
            KIND_WRITE: head_pop = issue;
            KIND_SKIP:  head_pop = issue;
            default:    head_pop = issue;
        endcase
        rd_addr = pal_addr(raw_addr);
        wr_addr = pal_addr(head.palette_index);
    end

    always_ff @(posedge aclk) begin
        if (issue && head.kind == KIND_WRITE) begin
            pal_mem[wr_addr] <= head.palette_color;
        end
        if (issue && head.kind == KIND_PIXELS) begin
            rdata_reg <= pal_mem[rd_addr];
        end
    end

    // color stage
    always_comb begin
        base = b_op_reg.clr ? 12'd0 : held_reg;
        color = rdata_reg;
        if (b_op_reg.ham) begin
            case (b_op_reg.ctrl)
                HAM_LOAD:  color = rdata_reg;
                HAM_BLUE:  color = {base[11:4], b_op_reg.data};
                HAM_RED:   color = {b_op_reg.data, base[7:0]};
                HAM_GREEN: color = {base[11:8], b_op_reg.data, base[3:0]};
                default:   color = rdata_reg;
            endcase
        end
        held_next    = held_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (advance) begin
            m_valid_next = b_valid_reg && b_op_reg.emit;
            if (b_valid_reg) begin
                if (b_op_reg.emit && b_op_reg.ham) begin
                    held_next = color;
                end else if (b_op_reg.clr) begin
                    held_next = 12'd0;
                end
                m_data_next.red   = lvl_out(color[11:8], b_op_reg.half);
                m_data_next.green = lvl_out(color[7:4], b_op_reg.half);
                m_data_next.blue  = lvl_out(color[3:0], b_op_reg.half);
                m_data_next.last  = b_op_reg.last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg       <= 4'd0;
            b_valid_reg <= 1'b0;
            held_reg    <= 12'd0;
            m_valid_reg <= 1'b0;
        end else begin
            x_reg       <= x_next;
            held_reg    <= held_next;
            m_valid_reg <= m_valid_next;
            if (advance) begin
                b_valid_reg <= issue && a_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            b_op_reg <= a_op;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a pixel group leaves the queue only on its final pixel
    a_pop_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        head_pop && head.kind == KIND_PIXELS |-> is_last)
        else $error("pixel group popped before its last pixel");

    // the pixel counter stays inside the group at the head
    a_x_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid && head.kind == KIND_PIXELS |-> x_reg < head.count)
        else $error("pixel counter past group end");

    // a token that emits nothing exists only to clear the held color
    a_token_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && !b_op_reg.emit |-> b_op_reg.clr)
        else $error("non-emitting token without clear");

    // a clear outside HAM leaves the held color at zero
    a_clear_held: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && b_valid_reg && b_op_reg.clr && !b_op_reg.ham |=> held_reg == 12'd0)
        else $error("held color not cleared at line start");

endmodule

`default_nettype wire

// ===== src/planar_to_rgb_ham_ehb_decoder.sv =====
// Top level of the planar to RGB decoder: configuration registers, front
// end, item queue and back end. Depends on p2rgb_pkg, p2rgb_front,
// p2rgb_queue and p2rgb_back.
//
//  channel  ports                      moves
//  -------  -------------------------  ------------------------------------
//  cfg      cfg_we cfg_index cfg_data  plane_count / color_mode write
//  s_       s_valid s_ready s_data     pixel group or palette write
//  m_       m_valid m_ready m_data     one RGB pixel, last on group end
//
// The back-end sequencer issues one palette read per clock while the output is not
// stalled, one pixel of a group at a time, and issues a palette write whole; m_valid
// rises once an accepted item has passed the queue slot and the palette read register.
// Reset is synchronous; palette contents stay undefined until written.
// m_ready low with m_valid high freezes the back end; s_ready drops once the two-entry queue is full.
`default_nettype none

module planar_to_rgb_ham_ehb_decoder #(
    parameter int PLANES_MAX      = 6,
    parameter int PALETTE_DEPTH   = 32,
    parameter int PIXELS_PER_ITEM = 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [2:0]          cfg_data,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  var p2rgb_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output var p2rgb_pkg::out_item_t m_data
);
    import p2rgb_pkg::*;

    logic [2:0] plane_count_reg;
    logic [1:0] color_mode_reg;
    entry_t     front_entry, head;
    logic       head_valid, head_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_count_reg <= 3'd1;
            color_mode_reg  <= MODE_NORMAL;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PLANE_COUNT: plane_count_reg <= cfg_data;
                CFG_COLOR_MODE:  color_mode_reg  <= cfg_data[1:0];
                default:         ;
            endcase
        end
    end

    p2rgb_front #(
        .PLANES_MAX      (PLANES_MAX),
        .PIXELS_PER_ITEM (PIXELS_PER_ITEM)
    ) u_front (
        .in_item     (s_data),
        .plane_count (plane_count_reg),
        .entry       (front_entry)
    );

    p2rgb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_entry  (front_entry),
        .out_valid (head_valid),
        .out_ready (head_pop),
        .out_entry (head)
    );

    p2rgb_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .color_mode (color_mode_reg),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .head       (head),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire
